// File: hw/rtl/mpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpc_pkg;

	localparam int ANGLE_ITERATIONS = 14;
	localparam int CORDIC_PRESCALE  = 8;
	localparam int ANG_PREC_SHIFT   = 7;
	localparam int HALF_PI_Q20      = 1647099;
	localparam int HEADING_MAX      = 25736;

	localparam int RAD_W   = 34;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int SQR_W   = ROOT_W + 4;
	localparam int NUM_W   = 38;
	localparam int DEN_W   = ROOT_W + 1;
	localparam int CX_W    = 28;
	localparam int CZ_W    = 23;

	// stage map
	localparam int SQ_FIRST  = 3;
	localparam int SQ_LAST   = SQ_FIRST + ROOT_W - 1;
	localparam int CR_FIRST  = 3;
	localparam int CR_LAST   = CR_FIRST + ANGLE_ITERATIONS - 1;
	localparam int HD_STAGE  = CR_LAST + 1;
	localparam int MUL_STAGE = SQ_LAST + 1;
	localparam int DIV_FIRST = MUL_STAGE + 1;
	localparam int DIV_LAST  = DIV_FIRST + NUM_W - 1;
	localparam int NST       = DIV_LAST + 1;

	localparam logic [7:0] REG_ORIGIN_X     = 8'd0;
	localparam logic [7:0] REG_ORIGIN_Y     = 8'd1;
	localparam logic [7:0] REG_FRAME_HEIGHT = 8'd2;
	localparam logic [7:0] REG_MARKER_SIZE  = 8'd3;

	typedef struct packed {
		logic [9:0]         id;
		logic signed [17:0] f2;
		logic signed [17:0] l2;
		logic signed [15:0] hd;
	} side_t;

	function automatic logic signed [CZ_W-1:0] atan_q20(input int i);
		case (i)
			0:  atan_q20 = 23'sd823550;
			1:  atan_q20 = 23'sd486170;
			2:  atan_q20 = 23'sd256879;
			3:  atan_q20 = 23'sd130396;
			4:  atan_q20 = 23'sd65451;
			5:  atan_q20 = 23'sd32757;
			6:  atan_q20 = 23'sd16383;
			7:  atan_q20 = 23'sd8192;
			8:  atan_q20 = 23'sd4096;
			9:  atan_q20 = 23'sd2048;
			10: atan_q20 = 23'sd1024;
			11: atan_q20 = 23'sd512;
			12: atan_q20 = 23'sd256;
			13: atan_q20 = 23'sd128;
			14: atan_q20 = 23'sd64;
			15: atan_q20 = 23'sd32;
			16: atan_q20 = 23'sd16;
			17: atan_q20 = 23'sd8;
			18: atan_q20 = 23'sd4;
			19: atan_q20 = 23'sd2;
			20: atan_q20 = 23'sd1;
			default: atan_q20 = 23'sd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/marker_pose_from_corners.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | handshake            | payload
// ------- | -------------------- | ------------------------------------------
// in      | start, busy          | marker_id, corner0..2_x/_y
// out     | done (1-cycle)       | robot_id, pos_x, pos_y, heading, degenerate
// cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One item per cycle, busy stays low.
// The depth is set by the bit-serial pipelines: 17 square-root stages and
// 38 divider stages in series; the CORDIC runs alongside.
// Reset clears the valid bits and loads default registers; cfg_ready is always high.
// Results cannot be stalled, so the pipe never holds.
module marker_pose_from_corners (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [9:0]         marker_id,
	input  wire logic [15:0]        corner0_x,
	input  wire logic [15:0]        corner0_y,
	input  wire logic [15:0]        corner1_x,
	input  wire logic [15:0]        corner1_y,
	input  wire logic [15:0]        corner2_x,
	input  wire logic [15:0]        corner2_y,
	output logic                    done,
	output logic [9:0]              robot_id,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [15:0]      heading,
	output logic                    degenerate,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int NST = mpc_pkg::NST;
	localparam int SQF = mpc_pkg::SQ_FIRST;
	localparam int SQL = mpc_pkg::SQ_LAST;
	localparam int CRF = mpc_pkg::CR_FIRST;
	localparam int CRL = mpc_pkg::CR_LAST;
	localparam int DVF = mpc_pkg::DIV_FIRST;
	localparam int DVL = mpc_pkg::DIV_LAST;
	localparam int MS  = mpc_pkg::MUL_STAGE;
	localparam int HDS = mpc_pkg::HD_STAGE;
	localparam int RW  = mpc_pkg::ROOT_W;
	localparam int SRW = mpc_pkg::SQR_W;
	localparam int ADW = mpc_pkg::RAD_W;
	localparam int NW  = mpc_pkg::NUM_W;
	localparam int DW  = mpc_pkg::DEN_W;
	localparam int XW  = mpc_pkg::CX_W;
	localparam int ZW  = mpc_pkg::CZ_W;

	logic [15:0] origin_x_q, origin_y_q, frame_height_q;
	logic [19:0] marker_size_q;

	logic              vld_s [1:NST];
	mpc_pkg::side_t    side_s [1:NST];
	logic signed [16:0] dx_s1, dy_s1;

	logic [ADW-1:0] sq_rad_s [2:SQL];
	logic [SRW-1:0] sq_rem_s [2:SQL];
	logic [RW-1:0]  sq_root_s [2:SQL];
	logic [ADW-1:0] sq_rad_n [SQF:SQL];
	logic [SRW-1:0] sq_rem_n [SQF:SQL];
	logic [RW-1:0]  sq_root_n [SQF:SQL];

	logic signed [XW-1:0] cx_s [2:CRL];
	logic signed [XW-1:0] cy_s [2:CRL];
	logic signed [ZW-1:0] cz_s [2:CRL];
	logic signed [XW-1:0] cx_n [CRF:CRL];
	logic signed [XW-1:0] cy_n [CRF:CRL];
	logic signed [ZW-1:0] cz_n [CRF:CRL];

	logic [NW-1:0]   qf_s [MS:DVL];
	logic [NW-1:0]   ql_s [MS:DVL];
	logic [DW-1:0]   rf_s [MS:DVL];
	logic [DW-1:0]   rl_s [MS:DVL];
	logic [DW-1:0]   den_s [MS:DVL];
	logic [NW-1:0]   qf_n [DVF:DVL];
	logic [NW-1:0]   ql_n [DVF:DVL];
	logic [DW-1:0]   rf_n [DVF:DVL];
	logic [DW-1:0]   rl_n [DVF:DVL];

	logic signed [ADW-1:0] sqx, sqy;
	logic signed [ZW-1:0]  hz, hz_abs;
	logic [ZW-1:0]         hz_r;
	logic signed [15:0]    hd_n;
	logic [16:0]           mf, ml;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= 16'd0;
			origin_y_q     <= 16'd7680;
			frame_height_q <= 16'd7680;
			marker_size_q  <= 20'd17340;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mpc_pkg::REG_ORIGIN_X:     origin_x_q     <= cfg_data[15:0];
				mpc_pkg::REG_ORIGIN_Y:     origin_y_q     <= cfg_data[15:0];
				mpc_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[15:0];
				mpc_pkg::REG_MARKER_SIZE:  marker_size_q  <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// frame height cancels out of the forward offset
	logic unused_fh;
	assign unused_fh = ^frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[1] <= start && !busy;
			for (int k = 2; k <= NST; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// squares and prerotation
	assign sqx = ADW'(dx_s1) * ADW'(dx_s1);
	assign sqy = ADW'(dy_s1) * ADW'(dy_s1);

	// integer square root, one result bit per stage
	always_comb begin
		for (int k = SQF; k <= SQL; k++) begin
			logic [SRW-1:0] r2, tr;
			r2 = {sq_rem_s[k-1][SRW-3:0], sq_rad_s[k-1][ADW-1:ADW-2]};
			tr = {{(SRW-RW-2){1'b0}}, sq_root_s[k-1], 2'b01};
			sq_rad_n[k] = {sq_rad_s[k-1][ADW-3:0], 2'b00};
			if (r2 >= tr) begin
				sq_rem_n[k]  = r2 - tr;
				sq_root_n[k] = {sq_root_s[k-1][RW-2:0], 1'b1};
			end else begin
				sq_rem_n[k]  = r2;
				sq_root_n[k] = {sq_root_s[k-1][RW-2:0], 1'b0};
			end
		end
	end

	// vectoring CORDIC, one iteration per stage
	always_comb begin
		for (int k = CRF; k <= CRL; k++) begin
			logic signed [XW-1:0] xs, ys;
			xs = cx_s[k-1] >>> (k - CRF);
			ys = cy_s[k-1] >>> (k - CRF);
			if (!cy_s[k-1][XW-1]) begin
				cx_n[k] = cx_s[k-1] + ys;
				cy_n[k] = cy_s[k-1] - xs;
				cz_n[k] = cz_s[k-1] + mpc_pkg::atan_q20(k - CRF);
			end else begin
				cx_n[k] = cx_s[k-1] - ys;
				cy_n[k] = cy_s[k-1] + xs;
				cz_n[k] = cz_s[k-1] - mpc_pkg::atan_q20(k - CRF);
			end
		end
	end

	assign hz     = cz_s[CRL];
	assign hz_abs = hz[ZW-1] ? -hz : hz;
	assign hz_r   = (ZW'(hz_abs) + ZW'(1 << (mpc_pkg::ANG_PREC_SHIFT - 1)))
		>> mpc_pkg::ANG_PREC_SHIFT;
	always_comb begin
		if (hz_r > ZW'(mpc_pkg::HEADING_MAX)) hd_n = 16'(mpc_pkg::HEADING_MAX);
		else                                  hd_n = 16'(hz_r);
		if (hz[ZW-1]) hd_n = -hd_n;
	end

	assign mf = side_s[MS-1].f2[17] ? 17'(-side_s[MS-1].f2) : 17'(side_s[MS-1].f2);
	assign ml = side_s[MS-1].l2[17] ? 17'(-side_s[MS-1].l2) : 17'(side_s[MS-1].l2);

	// restoring dividers, one quotient bit per stage
	always_comb begin
		for (int k = DVF; k <= DVL; k++) begin
			logic [DW:0] af, al;
			af = {rf_s[k-1], qf_s[k-1][NW-1]};
			al = {rl_s[k-1], ql_s[k-1][NW-1]};
			if (af >= {1'b0, den_s[k-1]}) begin
				rf_n[k] = DW'(af - {1'b0, den_s[k-1]});
				qf_n[k] = {qf_s[k-1][NW-2:0], 1'b1};
			end else begin
				rf_n[k] = DW'(af);
				qf_n[k] = {qf_s[k-1][NW-2:0], 1'b0};
			end
			if (al >= {1'b0, den_s[k-1]}) begin
				rl_n[k] = DW'(al - {1'b0, den_s[k-1]});
				ql_n[k] = {ql_s[k-1][NW-2:0], 1'b1};
			end else begin
				rl_n[k] = DW'(al);
				ql_n[k] = {ql_s[k-1][NW-2:0], 1'b0};
			end
		end
	end

	function automatic logic signed [31:0] sat_pos(input logic [NW-1:0] q, input logic neg);
		if (neg) begin
			if (q > NW'(64'h8000_0000)) sat_pos = 32'sh8000_0000;
			else                       sat_pos = -(32'(q));
		end else begin
			if (q > NW'(64'h7FFF_FFFF)) sat_pos = 32'sh7FFF_FFFF;
			else                       sat_pos = 32'(q);
		end
	endfunction

	always_ff @(posedge clk) begin
		side_s[1].id <= marker_id;
		side_s[1].f2 <= $signed({1'b0, origin_y_q, 1'b0})
			- $signed({2'b00, corner0_y} + {2'b00, corner2_y});
		side_s[1].l2 <= $signed({2'b00, corner0_x} + {2'b00, corner2_x})
			- $signed({1'b0, origin_x_q, 1'b0});
		side_s[1].hd <= 16'sd0;
		dx_s1 <= $signed({1'b0, corner1_x}) - $signed({1'b0, corner2_x});
		dy_s1 <= $signed({1'b0, corner1_y}) - $signed({1'b0, corner2_y});
		for (int k = 2; k <= NST; k++)
			if (k != HDS) side_s[k] <= side_s[k-1];
		side_s[HDS] <= '{id: side_s[HDS-1].id, f2: side_s[HDS-1].f2,
			l2: side_s[HDS-1].l2, hd: hd_n};

		sq_rad_s[2]  <= ADW'(sqx + sqy);
		sq_rem_s[2]  <= '0;
		sq_root_s[2] <= '0;
		for (int k = SQF; k <= SQL; k++) begin
			sq_rad_s[k]  <= sq_rad_n[k];
			sq_rem_s[k]  <= sq_rem_n[k];
			sq_root_s[k] <= sq_root_n[k];
		end

		if (dx_s1 < 0) begin
			if (dy_s1 >= 0) begin
				cx_s[2] <= XW'(dy_s1) <<< mpc_pkg::CORDIC_PRESCALE;
				cy_s[2] <= -(XW'(dx_s1) <<< mpc_pkg::CORDIC_PRESCALE);
				cz_s[2] <= ZW'(mpc_pkg::HALF_PI_Q20);
			end else begin
				cx_s[2] <= -(XW'(dy_s1) <<< mpc_pkg::CORDIC_PRESCALE);
				cy_s[2] <= XW'(dx_s1) <<< mpc_pkg::CORDIC_PRESCALE;
				cz_s[2] <= -ZW'(mpc_pkg::HALF_PI_Q20);
			end
		end else begin
			cx_s[2] <= XW'(dx_s1) <<< mpc_pkg::CORDIC_PRESCALE;
			cy_s[2] <= XW'(dy_s1) <<< mpc_pkg::CORDIC_PRESCALE;
			cz_s[2] <= '0;
		end
		for (int k = CRF; k <= CRL; k++) begin
			cx_s[k] <= cx_n[k];
			cy_s[k] <= cy_n[k];
			cz_s[k] <= cz_n[k];
		end

		// rounding: (mag*msize + dist) / (2*dist)
		qf_s[MS]  <= NW'(mf) * NW'(marker_size_q) + NW'(sq_root_s[SQL]);
		ql_s[MS]  <= NW'(ml) * NW'(marker_size_q) + NW'(sq_root_s[SQL]);
		rf_s[MS]  <= '0;
		rl_s[MS]  <= '0;
		den_s[MS] <= {sq_root_s[SQL], 1'b0};
		for (int k = DVF; k <= DVL; k++) begin
			qf_s[k]  <= qf_n[k];
			ql_s[k]  <= ql_n[k];
			rf_s[k]  <= rf_n[k];
			rl_s[k]  <= rl_n[k];
			den_s[k] <= den_s[k-1];
		end

		robot_id <= side_s[NST-1].id;
		if (den_s[DVL] == '0) begin
			degenerate <= 1'b1;
			pos_x      <= 32'sd0;
			pos_y      <= 32'sd0;
			heading    <= 16'sd0;
		end else begin
			degenerate <= 1'b0;
			pos_x      <= sat_pos(qf_s[DVL], side_s[NST-1].f2[17]);
			pos_y      <= sat_pos(ql_s[DVL], side_s[NST-1].l2[17]);
			heading    <= side_s[NST-1].hd;
		end
	end

	assign done = vld_s[NST];

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, NST))
		else $error("result without matching item");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (pos_x == 32'sd0 && pos_y == 32'sd0 && heading == 16'sd0))
		else $error("degenerate result not zeroed");
	a_hd_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (heading <= 16'sd25736 && heading >= -16'sd25736))
		else $error("heading out of range");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == mpc_pkg::REG_MARKER_SIZE)
		|=> marker_size_q == $past(cfg_data[19:0]))
		else $error("marker size write lost");
`endif

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

	typedef struct packed {
		logic [9:0]  id;
		logic [15:0] c0x, c0y, c1x, c1y, c2x, c2y;
	} marker_t;

	typedef struct packed {
		logic [9:0]         id;
		logic signed [31:0] px, py;
		logic signed [15:0] hd;
		logic               dg;
	} pose_t;

	localparam int MARKER_W     = $bits(marker_t);
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk, arst_n, start, busy, done, degenerate, cfg_valid, cfg_ready;
	logic [9:0] marker_id, robot_id;
	logic [15:0] corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y;
	logic signed [31:0] pos_x, pos_y;
	logic signed [15:0] heading;
	logic [7:0] cfg_index;
	logic [31:0] cfg_data;

	marker_pose_from_corners dut (.*);

	marker_t markers_to_send[$];
	pose_t   poses_due[$];
	int      errors = 0;
	int      cycles = 0;
	int      gap;

	// local copy of the block's registers
	logic [15:0] m_origin_x, m_origin_y, m_frame_h;
	logic [19:0] m_msize;

	longint atan_tab[14] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
		8192, 4096, 2048, 1024, 512, 256, 128};

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] to_metres(longint off2, longint ms, longint elen);
		longint num, den, mag, q;
		num = ms * off2;
		den = 2 * elen;
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		if (num < 0) q = -q;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function automatic logic signed [15:0] edge_angle(longint dx, longint dy);
		longint x, y, z, t, xs, ys, r;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = mpc_pkg::HALF_PI_Q20;
			end else begin
				x = -y; y = t; z = -mpc_pkg::HALF_PI_Q20;
			end
		end
		for (int i = 0; i < 14; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += atan_tab[i];
			end else begin
				x = x - ys; y = y + xs; z -= atan_tab[i];
			end
		end
		r = z >= 0 ? (z + 64) >>> 7 : -((-z + 64) >>> 7);
		if (r > mpc_pkg::HEADING_MAX) r = mpc_pkg::HEADING_MAX;
		if (r < -mpc_pkg::HEADING_MAX) r = -mpc_pkg::HEADING_MAX;
		return r[15:0];
	endfunction

	function automatic pose_t predict_pose(marker_t m);
		pose_t p;
		longint dx, dy, elen, f2, l2;
		dx = longint'(m.c1x) - longint'(m.c2x);
		dy = longint'(m.c1y) - longint'(m.c2y);
		elen = root_floor(dx * dx + dy * dy);
		p = '0;
		p.id = m.id;
		if (elen == 0) begin
			p.dg = 1'b1;
		end else begin
			f2 = 2 * longint'(m_origin_y) - longint'(m.c0y) - longint'(m.c2y);
			l2 = longint'(m.c0x) + longint'(m.c2x) - 2 * longint'(m_origin_x);
			p.px = to_metres(f2, m_msize, elen);
			p.py = to_metres(l2, m_msize, elen);
			p.hd = edge_angle(dx, dy);
		end
		return p;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("error: %s got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		marker_t nxt;
		logic go;
		if (!arst_n) begin
			start <= 1'b0;
			gap <= 0;
			{marker_id, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y} <= '0;
		end else begin
			go = 1'b0;
			if (start && !busy)
				poses_due.push_back(predict_pose({marker_id, corner0_x, corner0_y,
					corner1_x, corner1_y, corner2_x, corner2_y}));
			if (start && busy) begin
				go = 1'b1;
			end else if (gap > 0) begin
				gap <= gap - 1;
			end else if (markers_to_send.size() > 0) begin
				nxt = markers_to_send.pop_front();
				{marker_id, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
					corner2_y} <= nxt;
				go = 1'b1;
				if ($urandom_range(0, 9) == 0) gap <= $urandom_range(1, 12);
			end
			start <= go;
		end
	end

	// monitor
	always @(posedge clk) begin
		pose_t w;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("marker_pose_from_corners: mismatch");
			$finish;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				mpc_pkg::REG_ORIGIN_X:     m_origin_x <= cfg_data[15:0];
				mpc_pkg::REG_ORIGIN_Y:     m_origin_y <= cfg_data[15:0];
				mpc_pkg::REG_FRAME_HEIGHT: m_frame_h  <= cfg_data[15:0];
				mpc_pkg::REG_MARKER_SIZE:  m_msize    <= cfg_data[19:0];
				default: ;
			endcase
		end
		if (arst_n && done) begin
			if (poses_due.size() == 0) begin
				report("result with none due, id", robot_id, -1);
			end else begin
				w = poses_due.pop_front();
				if (robot_id !== w.id) report("robot_id", robot_id, w.id);
				if (pos_x !== w.px) report("pos_x", pos_x, w.px);
				if (pos_y !== w.py) report("pos_y", pos_y, w.py);
				if (heading !== w.hd) report("heading", heading, w.hd);
				if (degenerate !== w.dg) report("degenerate", degenerate, w.dg);
			end
		end
	end

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		do @(posedge clk);
		while (markers_to_send.size() > 0 || start || poses_due.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add(logic [9:0] id, logic [15:0] a, b, c, d, e, f);
		markers_to_send.push_back({id, a, b, c, d, e, f});
	endtask

	function automatic logic [15:0] offset(logic [15:0] base, int span);
		int v;
		v = int'(base) + $urandom_range(0, 2 * span) - span;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return v[15:0];
	endfunction

	task automatic add_random(int count);
		marker_t m;
		int span;
		repeat (count) begin
			m = MARKER_W'({$urandom, $urandom, $urandom, $urandom});
			case ($urandom_range(0, 9))
				0, 1: ;
				2, 3: begin
					span = $urandom_range(0, 3);
					m.c1x = offset(m.c2x, span);
					m.c1y = offset(m.c2y, span);
				end
				default: begin
					span = $urandom_range(16, 4000);
					m.c1x = offset(m.c2x, span);
					m.c1y = offset(m.c2y, span);
					m.c0x = offset(m.c2x, 2 * span);
					m.c0y = offset(m.c2y, 2 * span);
				end
			endcase
			markers_to_send.push_back(m);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_origin_x = 16'd0;
		m_origin_y = 16'd7680;
		m_frame_h = 16'd7680;
		m_msize = 20'd17340;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero edge, axis edges, negative-x edge, extremes
		add(10'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		add(10'h3ff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		add(10'd1, 16'd100, 16'd200, 16'd500, 16'd300, 16'd300, 16'd300);
		add(10'd2, 16'd100, 16'd200, 16'd100, 16'd300, 16'd300, 16'd300);
		add(10'd3, 16'd100, 16'd200, 16'd300, 16'd500, 16'd300, 16'd300);
		add(10'd4, 16'd100, 16'd200, 16'd300, 16'd100, 16'd300, 16'd300);
		add(10'd5, 16'd100, 16'd200, 16'd0, 16'd300, 16'hffff, 16'd300);
		add(10'd6, 16'hffff, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
		add(10'd7, 16'd0, 16'hffff, 16'hffff, 16'hffff, 16'hfffe, 16'hffff);
		add(10'd8, 16'd0, 16'd0, 16'hffff, 16'hffff, 16'd0, 16'd0);
		add(10'd9, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'hffff, 16'hffff);
		add(10'd10, 16'd0, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'hffff);
		add(10'd11, 16'd4000, 16'd4000, 16'd4001, 16'd3999, 16'd4000, 16'd4000);
		add(10'd12, 16'd9000, 16'd100, 16'd7000, 16'd7000, 16'd6000, 16'd6000);
		add(10'd13, 16'd9000, 16'd100, 16'd5000, 16'd5000, 16'd6000, 16'd6000);
		drain();

		// maximum registers make positions saturate
		write_reg(mpc_pkg::REG_ORIGIN_X, 32'hffff);
		write_reg(mpc_pkg::REG_ORIGIN_Y, 32'hffff);
		write_reg(mpc_pkg::REG_FRAME_HEIGHT, 32'hffff);
		write_reg(mpc_pkg::REG_MARKER_SIZE, 32'hfffff);
		add(10'd20, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
		add(10'd21, 16'hffff, 16'hffff, 16'hffff, 16'hfffe, 16'hffff, 16'hffff);
		add_random(400);
		drain();

		// zero registers; bits above the width and bad indexes are dropped
		write_reg(mpc_pkg::REG_ORIGIN_X, 32'hffff0000);
		write_reg(mpc_pkg::REG_ORIGIN_Y, 32'h12340000);
		write_reg(mpc_pkg::REG_FRAME_HEIGHT, 32'h0);
		write_reg(mpc_pkg::REG_MARKER_SIZE, 32'hfff00000);
		write_reg(8'd4, 32'hffffffff);
		write_reg(8'hff, 32'h5a5a5a5a);
		add(10'd30, 16'hffff, 16'hffff, 16'd2, 16'd3, 16'd1, 16'd1);
		add_random(300);
		drain();

		repeat (3) begin
			write_reg(mpc_pkg::REG_ORIGIN_X, $urandom);
			write_reg(mpc_pkg::REG_ORIGIN_Y, $urandom);
			write_reg(mpc_pkg::REG_FRAME_HEIGHT, $urandom);
			write_reg(mpc_pkg::REG_MARKER_SIZE, $urandom);
			add_random(200);
			drain();
			add_random(200);
			drain();
		end

		if (errors == 0) begin
			$display("marker_pose_from_corners: match");
		end else begin
			$display("marker_pose_from_corners: mismatch");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/mpc_pkg.sv
hw/rtl/marker_pose_from_corners.sv
bench/testbench.sv
